### src/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and constants for the max priority queue: operation codes,
// result status codes, the per-cell entry and the control word that the top
// level broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package mpq_pkg;

   localparam int DataWidth   = 32;
   localparam int StatusWidth = 2;

   // Operation encoding of the request's func field.
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   typedef enum logic [StatusWidth-1:0] {
      ST_INSERTED  = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_REMOVED   = 2'd2,
      ST_UNDERFLOW = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CMD_HOLD   = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_REMOVE = 2'd2
   } cmd_type;

   typedef struct packed {
      logic                        valid;
      logic signed [DataWidth-1:0] data;
      logic signed [DataWidth-1:0] prio;
   } entry_type;

   typedef struct packed {
      cmd_type                     cmd;
      logic signed [DataWidth-1:0] new_data;
      logic signed [DataWidth-1:0] new_prio;
   } cell_ctrl_type;

   // Largest signed priority; stands in front of the head cell so that
   // nothing is ever pushed into the head from the left.
   localparam logic signed [DataWidth-1:0] PrioMax = {1'b0, {(DataWidth-1){1'b1}}};

endpackage

### src/mpq_if.sv
// ----------------------------------------------------------------------------
// mpq_if
// Valid/ready channels of the max priority queue: the request channel that
// carries inserts and removes, and the response channel with one result per
// request.
// ----------------------------------------------------------------------------
interface mpq_req_if;
   logic               valid;
   logic               ready;
   logic               func;
   logic signed [31:0] item_value;
   logic signed [31:0] item_priority;

   modport source (output valid, func, item_value, item_priority, input ready);
   modport sink   (input valid, func, item_value, item_priority, output ready);
endinterface

interface mpq_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] out_value;
   logic signed [31:0] out_priority;

   modport source (output valid, status, out_value, out_priority, input ready);
   modport sink   (input valid, status, out_value, out_priority, output ready);
endinterface

### src/mpq_cell.sv
// ----------------------------------------------------------------------------
// mpq_cell
// One place of the sorted chain. It holds a single entry and, on each
// command, keeps it, takes the broadcast new entry, takes its left
// neighbor's entry (insert shifts right) or its right neighbor's (remove
// shifts left).
// ----------------------------------------------------------------------------
module mpq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  mpq_pkg::cell_ctrl_type ctrl,
   input  mpq_pkg::entry_type     left_entry,
   input  mpq_pkg::entry_type     right_entry,
   output mpq_pkg::entry_type     own_entry
);
   import mpq_pkg::*;

   logic                        valid_ff, valid_in;
   logic signed [DataWidth-1:0] data_ff, data_in;
   logic signed [DataWidth-1:0] prio_ff, prio_in;
   logic                        left_moves;
   logic                        own_less;

   // The left neighbor is displaced when the new priority beats it strictly;
   // equal priorities stay ahead so arrival order is kept among ties.
   assign left_moves = left_entry.valid && (left_entry.prio < ctrl.new_prio);
   assign own_less   = !valid_ff || (prio_ff < ctrl.new_prio);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      prio_in  = prio_ff;
      unique case (ctrl.cmd)
         CMD_INSERT: begin
            if (left_moves) begin
               valid_in = 1'b1;
               data_in  = left_entry.data;
               prio_in  = left_entry.prio;
            end else if (own_less && left_entry.valid) begin
               valid_in = 1'b1;
               data_in  = ctrl.new_data;
               prio_in  = ctrl.new_prio;
            end
         end
         CMD_REMOVE: begin
            valid_in = right_entry.valid;
            data_in  = right_entry.data;
            prio_in  = right_entry.prio;
         end
         CMD_HOLD: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      prio_ff <= prio_in;
   end

   assign own_entry.valid = valid_ff;
   assign own_entry.data  = data_ff;
   assign own_entry.prio  = prio_ff;

endmodule

### src/max_priority_queue.sv
// ----------------------------------------------------------------------------
// max_priority_queue
// Bounded max priority queue built as a chain of sorted cells.
// ----------------------------------------------------------------------------
// The queue holds up to CAPACITY entries in a row of cells kept sorted by
// priority, highest first, with equal priorities in arrival order, so the head
// cell always holds the entry that a remove returns. At each request transfer
// the command is broadcast to all cells, each cell compares the new priority
// with its own entry and its left neighbor's, and the row shifts right from
// the insertion point (insert) or wholly left (remove) in that same edge.
// The result is registered and appears on the response channel the cycle
// after the request transfer, so one request per cycle is sustained as long
// as responses are taken; the request side stalls only while a result waits
// in the output register and the response side is not ready. An insert into a
// full queue reports overflow and stores nothing; a remove from an empty queue
// reports underflow. Value and priority are zero but on a successful remove.
// ----------------------------------------------------------------------------
module max_priority_queue #(
   parameter int CAPACITY = 128
) (
   input logic clock,
   input logic reset,
   mpq_req_if.sink   req_chan,
   mpq_rsp_if.source rsp_chan
);
   import mpq_pkg::*;

   // Entry held by each cell, and the guards at both ends of the chain.
   entry_type     cell_entry [CAPACITY];
   entry_type     head_guard;
   entry_type     tail_guard;
   cell_ctrl_type cell_ctrl;

   logic req_transfer;
   logic queue_full;
   logic queue_empty;

   // Output register.
   logic                        rsp_valid_ff, rsp_valid_in;
   status_type                  rsp_status_ff, rsp_status_in;
   logic signed [DataWidth-1:0] rsp_value_ff, rsp_value_in;
   logic signed [DataWidth-1:0] rsp_prio_ff, rsp_prio_in;

   // The head guard is valid with the largest priority so the head cell
   // never takes a shifted entry, only the new one. The tail guard is empty
   // so a remove clears the last cell.
   assign head_guard.valid = 1'b1;
   assign head_guard.data  = '0;
   assign head_guard.prio  = PrioMax;
   assign tail_guard.valid = 1'b0;
   assign tail_guard.data  = '0;
   assign tail_guard.prio  = '0;

   // The chain is packed from the head, so fill state shows at its ends.
   assign queue_full  = cell_entry[CAPACITY-1].valid;
   assign queue_empty = !cell_entry[0].valid;

   // A new request is taken whenever the output register is free or is
   // being emptied in this cycle.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_transfer   = req_chan.valid && req_chan.ready;

   always_comb begin
      cell_ctrl.cmd      = CMD_HOLD;
      cell_ctrl.new_data = req_chan.item_value;
      cell_ctrl.new_prio = req_chan.item_priority;
      rsp_status_in      = rsp_status_ff;
      rsp_value_in       = rsp_value_ff;
      rsp_prio_in        = rsp_prio_ff;
      if (req_transfer) begin
         rsp_value_in = '0;
         rsp_prio_in  = '0;
         if (req_chan.func == FUNC_INSERT) begin
            if (queue_full) begin
               rsp_status_in = ST_OVERFLOW;
            end else begin
               cell_ctrl.cmd = CMD_INSERT;
               rsp_status_in = ST_INSERTED;
            end
         end else begin
            if (queue_empty) begin
               rsp_status_in = ST_UNDERFLOW;
            end else begin
               // The head cell holds the highest priority, earliest arrival.
               cell_ctrl.cmd = CMD_REMOVE;
               rsp_status_in = ST_REMOVED;
               rsp_value_in  = cell_entry[0].data;
               rsp_prio_in   = cell_entry[0].prio;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_transfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;

      if (i == 0) begin : g_head
         assign left_entry = head_guard;
      end else begin : g_body
         assign left_entry = cell_entry[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_entry = tail_guard;
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      mpq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .own_entry   (cell_entry[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_prio_ff   <= rsp_prio_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.out_value    = rsp_value_ff;
   assign rsp_chan.out_priority = rsp_prio_ff;

endmodule
